// File: rtl/hkm_pkg.sv
// ---------------------------------------------------------------------------
// hkm_pkg: shared types and constants for the heap k-way merge engine
// Heap entry layout, controller/datapath command and status bundles, and
// the heap ordering function.
// ---------------------------------------------------------------------------
package hkm_pkg;

  localparam int MAX_RUNS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(MAX_RUNS);
  localparam int CNT_W      = $clog2(MAX_RUNS + 1);
  localparam int RUN_W      = 4;
  localparam int VALUE_W    = 32;
  localparam int CFG_W      = 5;
  localparam logic [CFG_W-1:0] RUNS_RESET = CFG_W'(16);

  typedef struct packed {
    logic                         live;
    logic [RUN_W-1:0]             run;
    logic signed [VALUE_BITS-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;       // append the input head at the fill position
    logic merge;      // replace the root with the next value of the emitted run
    logic bld_init;   // start the bottom-up build
    logic bld_rd;     // read the entry at the build index
    logic bld_ld;     // take that entry as the element to sift
    logic put_cur;    // sifting element settles at the current position
    logic put_kid;    // smaller child moves up, sift continues below
    logic bi_dec;     // step the build index down
    logic emit;       // capture the result
  } hkm_cmd_t;

  typedef struct packed {
    logic merging;
    logic load_more;
    logic cnt_zero;
    logic lc_in;
    logic move;
    logic bi_zero;
  } hkm_sts_t;

  // Live entries order before ended ones; live entries compare signed.
  function automatic logic entry_less(entry_t a, entry_t b);
    logic r;
    if (a.live && !b.live) begin
      r = 1'b1;
    end else if (!a.live) begin
      r = 1'b0;
    end else begin
      r = (a.value < b.value);
    end
    return r;
  endfunction

endpackage

// File: rtl/heap_kway_merge.sv
// ---------------------------------------------------------------------------
// heap_kway_merge: k-way merge engine on a binary min-heap
// Loads one head per run, builds the heap bottom-up, then replaces and
// sifts the root once per incoming value and returns the running minimum.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------
//  item     | item_valid / item_stall  | value, run_ends
//  result   | res_valid / res_stall    | min_value, source_run, done_res
//  config   | cfg_valid / cfg_ready    | num_runs
//
// A loading item that does not finish the load is written straight into the
// heap. A merging item is accepted, then its element moves down one level at
// a time, each level read from the two-read-port heap RAM and compared; the
// element is then settled and its result handed off. The final load adds
// the bottom-up build, up to about 8 sift-downs.
// Reset (rst, synchronous) returns to the loading phase with num_runs at 16.
// A stalled result is held in its register; the next item is still taken
// and its result waits until the register frees.
module heap_kway_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic signed [hkm_pkg::VALUE_W-1:0] value,
  input  logic                               run_ends,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [hkm_pkg::VALUE_W-1:0] min_value,
  output logic [hkm_pkg::RUN_W-1:0]          source_run,
  output logic                               done_res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hkm_pkg::CFG_W-1:0]          num_runs
);
  import hkm_pkg::*;

  logic [CFG_W-1:0] runs_cfg;
  hkm_cmd_t         cmd;
  hkm_sts_t         sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      runs_cfg <= RUNS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      runs_cfg <= num_runs;
    end
  end

  hkm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .run_ends   (run_ends),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  hkm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .runs_cfg   (runs_cfg),
    .value      (value),
    .run_ends   (run_ends),
    .min_value  (min_value),
    .source_run (source_run),
    .done_res   (done_res)
  );

endmodule

// File: rtl/hkm_ram.sv
// ---------------------------------------------------------------------------
// hkm_ram: generic RAM, one write port and two registered read ports
// ---------------------------------------------------------------------------
module hkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/hkm_dp.sv
// ---------------------------------------------------------------------------
// hkm_dp: heap datapath
// Heap storage, fill and exhausted counters, sift position, build index,
// child compare and the result register.
// ---------------------------------------------------------------------------
module hkm_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  hkm_pkg::hkm_cmd_t            cmd,
  output hkm_pkg::hkm_sts_t            sts,
  input  logic [hkm_pkg::CFG_W-1:0]    runs_cfg,
  input  logic signed [hkm_pkg::VALUE_W-1:0] value,
  input  logic                         run_ends,
  output logic signed [hkm_pkg::VALUE_W-1:0] min_value,
  output logic [hkm_pkg::RUN_W-1:0]    source_run,
  output logic                         done_res
);
  import hkm_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] exhausted;
  logic             merging;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] bi;
  entry_t           cur;
  entry_t           root;

  logic [IDX_W:0]   lc;
  logic [IDX_W+1:0] rc;
  logic             rc_in;
  logic [CNT_W:0]   cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  entry_t           kid_a;
  entry_t           kid_b;
  entry_t           best_l;
  logic             take_l;
  logic             take_r;
  entry_t           best;
  logic [IDX_W-1:0] best_idx;
  logic             all_ended;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic [IDX_W-1:0]   raddr_a;
  logic [ENTRY_W-1:0] rdata_a;
  logic [ENTRY_W-1:0] rdata_b;
  entry_t             in_entry;
  entry_t             new_root;

  assign lc      = {pos, 1'b1};
  assign rc      = {1'b0, pos, 1'b0} + (IDX_W+2)'(2);
  assign rc_in   = ((IDX_W+2)'(rc) < (IDX_W+2)'(count));
  assign cnt_inc = {1'b0, count} + (CNT_W+1)'(1);
  assign cnt_dec = count - CNT_W'(1);

  assign kid_a  = entry_t'(rdata_a);
  assign kid_b  = entry_t'(rdata_b);
  assign take_l = sts.lc_in && entry_less(kid_a, cur);
  assign best_l = take_l ? kid_a : cur;
  assign take_r = rc_in && entry_less(kid_b, best_l);
  assign best     = take_r ? kid_b : kid_a;
  assign best_idx = take_r ? rc[IDX_W-1:0] : lc[IDX_W-1:0];

  assign all_ended = (exhausted >= count);

  // The effective run count is num_runs clamped to 1..MAX_RUNS; a zero
  // setting fails the first compare, which is the same as a count of one.
  assign sts.merging   = merging;
  assign sts.load_more = (32'(cnt_inc) < 32'(runs_cfg)) && (32'(cnt_inc) < 32'(MAX_RUNS));
  assign sts.cnt_zero  = (count == '0);
  assign sts.lc_in     = ((IDX_W+1)'(lc) < (IDX_W+1)'(count));
  assign sts.move      = take_l || take_r;
  assign sts.bi_zero   = (bi == '0);

  assign in_entry.live  = 1'b1;
  assign in_entry.run   = RUN_W'(count);
  assign in_entry.value = VALUE_BITS'(value);

  assign new_root.live  = !run_ends;
  assign new_root.run   = root.run;
  assign new_root.value = run_ends ? '0 : VALUE_BITS'(value);

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = cur;
    if (cmd.load) begin
      we    = 1'b1;
      waddr = IDX_W'(count);
      wdata = in_entry;
    end else if (cmd.put_kid) begin
      we    = 1'b1;
      wdata = best;
    end else if (cmd.put_cur) begin
      we    = 1'b1;
    end
  end

  assign raddr_a = cmd.bld_rd ? bi : lc[IDX_W-1:0];

  hkm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RUNS)
  ) u_heap (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (rc[IDX_W-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      exhausted <= '0;
      merging   <= 1'b0;
    end else begin
      if (cmd.load) begin
        count <= CNT_W'(cnt_inc);
      end
      if (cmd.merge && run_ends) begin
        exhausted <= exhausted + CNT_W'(1);
      end
      if (cmd.bld_init) begin
        exhausted <= '0;
        merging   <= 1'b1;
      end
      // A done result ends the merge and rearms loading.
      if (cmd.emit && all_ended) begin
        count     <= '0;
        exhausted <= '0;
        merging   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      cur <= new_root;
      pos <= '0;
      bi  <= '0;
    end
    if (cmd.bld_init) begin
      bi <= IDX_W'(cnt_dec >> 1);
    end
    if (cmd.bld_ld) begin
      cur <= kid_a;
      pos <= bi;
    end
    if (cmd.bi_dec) begin
      bi <= bi - IDX_W'(1);
    end
    if (cmd.put_kid) begin
      pos <= best_idx;
    end
    // Whatever lands at the top of the heap is the next minimum.
    if ((cmd.put_kid || cmd.put_cur) && (pos == '0)) begin
      root <= wdata;
    end
    if (cmd.emit) begin
      done_res   <= all_ended;
      min_value  <= all_ended ? '0 : VALUE_W'(root.value);
      source_run <= all_ended ? '0 : root.run;
    end
  end

endmodule

// File: rtl/hkm_ctrl.sv
// ---------------------------------------------------------------------------
// hkm_ctrl: merge controller
// Sequences loading, heap build, sift-down and result hand-off.
// ---------------------------------------------------------------------------
module hkm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              run_ends,
  output logic              res_valid,
  input  logic              res_stall,
  output hkm_pkg::hkm_cmd_t cmd,
  input  hkm_pkg::hkm_sts_t sts
);
  import hkm_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_BLD_INIT = 7'b0000010,
    ST_BLD_RD   = 7'b0000100,
    ST_BLD_LD   = 7'b0001000,
    ST_SIFT_RD  = 7'b0010000,
    ST_SIFT_CMP = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (sts.merging) begin
            cmd.merge  = 1'b1;
            state_next = ST_SIFT_RD;
          end else if (!run_ends) begin
            cmd.load = 1'b1;
            if (!sts.load_more) begin
              state_next = ST_BLD_INIT;
            end
          end else if (sts.cnt_zero) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_BLD_INIT;
          end
        end
      end
      ST_BLD_INIT: begin
        cmd.bld_init = 1'b1;
        state_next   = ST_BLD_RD;
      end
      ST_BLD_RD: begin
        cmd.bld_rd = 1'b1;
        state_next = ST_BLD_LD;
      end
      ST_BLD_LD: begin
        cmd.bld_ld = 1'b1;
        state_next = ST_SIFT_RD;
      end
      ST_SIFT_RD: begin
        if (sts.lc_in) begin
          state_next = ST_SIFT_CMP;
        end else begin
          cmd.put_cur = 1'b1;
          if (!sts.bi_zero) begin
            cmd.bi_dec = 1'b1;
            state_next = ST_BLD_RD;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SIFT_CMP: begin
        if (sts.move) begin
          cmd.put_kid = 1'b1;
          state_next  = ST_SIFT_RD;
        end else begin
          cmd.put_cur = 1'b1;
          if (!sts.bi_zero) begin
            cmd.bi_dec = 1'b1;
            state_next = ST_BLD_RD;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for heap_kway_merge
// Drives merge items and run-count writes into the engine, predicts results
// with an in-bench min-heap model (directed rows may give their own), and
// checks each result field by field under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;
  import hkm_pkg::MAX_RUNS;
  import hkm_pkg::VALUE_W;
  import hkm_pkg::RUN_W;
  import hkm_pkg::CFG_W;

  localparam int DRAIN_CYCLES = 96;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 160;

  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                      live;
    logic [RUN_W-1:0]          run;
    logic signed [VALUE_W-1:0] val;
  } slot_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] mval;
    logic [RUN_W-1:0]          srun;
    logic                      fin;
  } merge_out_t;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    logic signed [VALUE_W-1:0] val;
    logic                      ends;
    logic [CFG_W-1:0]          runs;
    bit                        typed;
    merge_out_t                want;
  } dir_row_t;

  localparam merge_out_t NO_RES   = '0;
  localparam merge_out_t DONE_RES = '{mval: '0, srun: '0, fin: 1'b1};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_stall;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      run_ends = 1'b0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic signed [VALUE_W-1:0] min_value;
  logic [RUN_W-1:0]          source_run;
  logic                      done_res;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          num_runs = '0;

  // Shadow of the engine: heap, counts, phase and the run-count register.
  slot_t            pheap [MAX_RUNS];
  int unsigned      fill = 0;
  int unsigned      retired = 0;
  bit               merging = 1'b0;
  logic [CFG_W-1:0] runs_cfg = CFG_W'(16);

  merge_out_t minima_due[$];
  dir_row_t   dir_rows [30];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int results_seen = 0;
  int merges_done = 0;
  int cfg_writes = 0;
  int errors = 0;
  int cycles = 0;

  heap_kway_merge dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .run_ends   (run_ends),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .min_value  (min_value),
    .source_run (source_run),
    .done_res   (done_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .num_runs   (num_runs)
  );

  always #2 clk = ~clk;

  // Live slots order before retired ones; live slots compare signed.
  function automatic bit slot_before(slot_t a, slot_t b);
    if (a.live && !b.live) return 1'b1;
    if (!a.live) return 1'b0;
    return $signed(a.val) < $signed(b.val);
  endfunction

  function automatic void sift_down_from(int unsigned pos);
    int unsigned lc;
    int unsigned best;
    slot_t       tmp;
    bit          settled;
    settled = 1'b0;
    while (!settled && pos < fill) begin
      lc = 2 * pos + 1;
      best = pos;
      if (lc < fill && slot_before(pheap[lc], pheap[best])) best = lc;
      if (lc + 1 < fill && slot_before(pheap[lc + 1], pheap[best])) best = lc + 1;
      if (best == pos) begin
        settled = 1'b1;
      end else begin
        tmp = pheap[pos];
        pheap[pos] = pheap[best];
        pheap[best] = tmp;
        pos = best;
      end
    end
  endfunction

  // Advances the shadow heap by one item; returns 1 when the item yields a result.
  function automatic bit next_minimum(input logic signed [VALUE_W-1:0] v, input logic e,
                                      output merge_out_t r);
    int unsigned k;
    r = '0;
    if (!merging) begin
      k = (runs_cfg == 0) ? 1 : runs_cfg;
      if (k > MAX_RUNS) k = MAX_RUNS;
      if (!e) begin
        if (fill < MAX_RUNS) begin
          pheap[fill] = '{live: 1'b1, run: RUN_W'(fill), val: v};
          fill++;
        end
        if (fill < k && fill < MAX_RUNS) return 1'b0;
      end
      if (fill == 0) begin
        r.fin = 1'b1;
        retired = 0;
        return 1'b1;
      end
      for (int i = (fill - 1) / 2 + 1; i > 0; i--) sift_down_from(i - 1);
      retired = 0;
      merging = 1'b1;
      r.mval = pheap[0].val;
      r.srun = pheap[0].run;
      return 1'b1;
    end
    if (e) begin
      pheap[0].live = 1'b0;
      pheap[0].val = '0;
      retired++;
    end else begin
      pheap[0].val = v;
    end
    sift_down_from(0);
    if (retired >= fill) begin
      r.fin = 1'b1;
      fill = 0;
      retired = 0;
      merging = 1'b0;
      return 1'b1;
    end
    r.mval = pheap[0].val;
    r.srun = pheap[0].run;
    return 1'b1;
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: v = VMIN;
          1: v = VMAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1, 2, 3: begin
        // A narrow band makes equal values, and so tie-breaking, common.
        v = VALUE_W'(int'($urandom_range(16)) - 8);
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_runs();
    logic [CFG_W-1:0] n;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: n = CFG_W'($urandom_range(4, 1));
      6: n = CFG_W'(16);
      7: n = CFG_W'($urandom_range(15, 5));
      8: n = ($urandom_range(1) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(31, 17));
      default: n = CFG_W'(2);
    endcase
    return n;
  endfunction

  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic e,
                           input bit typed, input merge_out_t want);
    merge_out_t pred;
    bit         got;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    value <= v;
    run_ends <= e;
    do @(posedge clk); while (item_stall);
    got = next_minimum(v, e, pred);
    if (typed) minima_due.push_back(want);
    else if (got) minima_due.push_back(pred);
    items_sent++;
  endtask

  // The register may only change while the engine is idle.
  task automatic write_runs(input logic [CFG_W-1:0] n);
    item_valid <= 1'b0;
    @(posedge clk);
    while (minima_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    num_runs <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    runs_cfg = n;
    cfg_writes++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    merge_out_t w;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (done_res === 1'b1) merges_done++;
      if (minima_due.size() == 0) begin
        $display("%0t: result with nothing expected: min_value=%0d source_run=%0d done_res=%0b",
                 $time, min_value, source_run, done_res);
        errors++;
      end else begin
        w = minima_due.pop_front();
        if (min_value !== w.mval || source_run !== w.srun || done_res !== w.fin) begin
          $display("%0t: mismatch expected min_value=%0d source_run=%0d done_res=%0b",
                   $time, w.mval, w.srun, w.fin);
          $display("%0t:          actual   min_value=%0d source_run=%0d done_res=%0b",
                   $time, min_value, source_run, done_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, minima_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int end_pct;
    dir_rows = '{
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b1, DONE_RES},  // empty merge
      '{ROW_CFG,  32'sd0, 1'b0, 5'd1,  1'b0, NO_RES},
      '{ROW_ITEM, VMIN,   1'b0, 5'd0,  1'b1, '{VMIN, 4'd0, 1'b0}},
      '{ROW_ITEM, VMAX,   1'b0, 5'd0,  1'b1, '{VMAX, 4'd0, 1'b0}},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b1, DONE_RES},
      '{ROW_CFG,  32'sd0, 1'b0, 5'd0,  1'b0, NO_RES},    // zero acts as one
      '{ROW_ITEM, 32'sd5, 1'b0, 5'd0,  1'b1, '{32'sd5, 4'd0, 1'b0}},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b1, DONE_RES},
      '{ROW_CFG,  32'sd0, 1'b0, 5'd3,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd7, 1'b0, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, -32'sd1, 1'b0, 5'd0, 1'b0, NO_RES},
      '{ROW_ITEM, VMAX,   1'b0, 5'd0,  1'b0, NO_RES},    // live maximum vs ended run
      '{ROW_ITEM, 32'sd3, 1'b0, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b0, NO_RES},
      '{ROW_CFG,  32'sd0, 1'b0, 5'd31, 1'b0, NO_RES},    // clamps to the heap size
      '{ROW_ITEM, 32'sd0, 1'b0, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd0, 1'b0, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd9, 1'b1, 5'd0,  1'b0, NO_RES},    // ends loading early
      '{ROW_CFG,  32'sd0, 1'b0, 5'd4,  1'b0, NO_RES},    // written while merging
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd10, 1'b0, 5'd0, 1'b0, NO_RES},
      '{ROW_ITEM, 32'sd20, 1'b0, 5'd0, 1'b0, NO_RES},
      '{ROW_CFG,  32'sd0, 1'b0, 5'd2,  1'b0, NO_RES},    // written while loading
      '{ROW_ITEM, -32'sd5, 1'b0, 5'd0, 1'b0, NO_RES},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b0, NO_RES},
      '{ROW_ITEM, 32'sd0, 1'b1, 5'd0,  1'b0, NO_RES}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(dir_rows); i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_runs(dir_rows[i].runs);
      end else begin
        send_item(dir_rows[i].val, dir_rows[i].ends, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      int phase_end;
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(1) == 0) write_runs(pick_runs());
        end_pct = $urandom_range(40, 15);
        // Loading: heads with random content, now and then a broken load.
        while (!merging && items_sent < phase_end) begin
          if ($urandom_range(99) < 3) write_runs(pick_runs());
          if ($urandom_range(99) < 4) send_item(rand_value(), 1'b1, 1'b0, NO_RES);
          else send_item(rand_value(), 1'b0, 1'b0, NO_RES);
        end
        // Merging runs until every run has ended.
        while (merging) begin
          if ($urandom_range(99) < 2) write_runs(pick_runs());
          send_item(rand_value(), $urandom_range(99) < end_pct, 1'b0, NO_RES);
        end
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (minima_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items over four idle/stall mixes; checked %0d results.",
             items_sent, results_seen);
    $display("Completed %0d merges with %0d run-count writes; %0d mismatches.",
             merges_done, cfg_writes, errors);
    if (errors == 0 && minima_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hkm_pkg.sv
rtl/hkm_ram.sv
rtl/hkm_dp.sv
rtl/hkm_ctrl.sv
rtl/heap_kway_merge.sv
test/testbench.sv
